FILE: hw/rtl/rofd_pkg.sv
// Package for the radar object frame decoder: sizes, frame identifiers,
// scaling offsets and the command/status structs between controller and datapath.
// No dependencies.
package rofd_pkg;

  localparam int MAX_OBJECTS = 64;
  localparam int ADDR_W      = $clog2(MAX_OBJECTS);
  localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
  localparam int CYC_W       = 16;
  localparam int DIV_STEPS   = CYC_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [10:0] ID_OBJECT = 11'h60B;
  localparam logic [10:0] ID_STATUS = 11'h60A;
  localparam logic [3:0]  DLC_FULL  = 4'd8;

  localparam logic [14:0] DIST_LONG_OFS = 15'd5000;
  localparam logic [12:0] DIST_LAT_OFS  = 13'd2042;

  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic div_step;   // one remainder step
    logic rd_en;      // read the object store at the walk index
    logic load_out;   // load the output register
    logic advance;    // move the walk index to the next object
  } rofd_cmd_t;

  typedef struct packed {
    logic start_run;  // the offered frame is a status frame
    logic div_last;   // final remainder step this cycle
    logic empty;      // the finished scan holds no objects
    logic out_last;   // the shown result closes the run
  } rofd_stat_t;

endpackage

FILE: hw/rtl/rofd_ctrl.sv
// Controller for the radar object frame decoder: sequences the publish
// remainder, the object store walk and the output handshake.
// Depends on rofd_pkg.
module rofd_ctrl
  import rofd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  rofd_stat_t stat,
  output rofd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_FMT,
    S_SHOW
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.div_step = (state == S_DIV);
    cmd.rd_en    = (state == S_READ);
    cmd.load_out = (state == S_FMT);
    cmd.advance  = (state == S_SHOW) && !out_stall && !stat.out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept && stat.start_run) state <= S_DIV;
        end
        S_DIV: begin
          if (stat.div_last) state <= stat.empty ? S_FMT : S_READ;
        end
        S_READ: begin
          state <= S_FMT;
        end
        S_FMT: begin
          out_valid <= 1'b1;
          state     <= S_SHOW;
        end
        S_SHOW: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= stat.out_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/rofd_datapath.sv
// Datapath for the radar object frame decoder: frame decode, object store,
// scan registers, bit-serial remainder unit and the output register.
// Depends on rofd_pkg.
module rofd_datapath
  import rofd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic [10:0]       frame_id,
  input  logic [3:0]        frame_len,
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte1,
  input  logic [7:0]        byte2,
  input  logic [7:0]        byte3,
  input  logic [7:0]        byte4,
  input  logic [7:0]        byte5,
  input  logic [7:0]        byte6,
  input  logic [7:0]        byte7,
  input  rofd_cmd_t         cmd,
  output rofd_stat_t        stat,
  output logic              last,
  output logic [8:0]        obj_id,
  output logic signed [14:0] dist_long,
  output logic signed [12:0] dist_lat,
  output logic signed [9:0] vel_long,
  output logic signed [8:0] vel_lat,
  output logic [1:0]        obj_class,
  output logic [2:0]        dyn_prop,
  output logic signed [7:0] rcs_half_db,
  output logic [6:0]        detected_count,
  output logic              complete,
  output logic              publish
);

  logic [63:0]       store [MAX_OBJECTS];
  logic [63:0]       rd_q;
  logic [7:0]        skip_cycles;
  logic [CNT_W-1:0]  object_count;
  logic [7:0]        announced_total;
  logic [CYC_W-1:0]  cycle_count;
  logic [CNT_W-1:0]  run_count;
  logic              run_done;
  logic [ADDR_W-1:0] walk_idx;

  logic [CYC_W-1:0]  dvd;
  logic [8:0]        rem;
  logic [STEP_W-1:0] step;
  logic [9:0]        trial;
  logic [8:0]        divisor;

  logic              is_full_len;
  logic              is_object;
  logic              is_status;
  logic [63:0]       raw_in;

  logic [12:0]       dl;
  logic [10:0]       dt;
  logic [9:0]        vl;
  logic [8:0]        vt;

  assign is_full_len = (frame_len == DLC_FULL);
  assign is_object   = is_full_len && ((frame_id & ID_OBJECT) == ID_OBJECT);
  assign is_status   = is_full_len && !((frame_id & ID_OBJECT) == ID_OBJECT)
                       && ((frame_id & ID_STATUS) == ID_STATUS);
  assign raw_in      = {byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7};

  assign divisor = {1'b0, skip_cycles} + 9'd1;
  assign trial   = {rem, dvd[CYC_W-1]};

  assign stat.start_run = is_status;
  assign stat.div_last  = (step == STEP_W'(DIV_STEPS - 1));
  assign stat.empty     = (run_count == '0);
  assign stat.out_last  = last;

  // Raw object fields from the stored frame, first data byte at the top.
  assign dl = {rd_q[55:48], rd_q[47:43]};
  assign dt = {rd_q[42:40], rd_q[39:32]};
  assign vl = {rd_q[31:24], rd_q[23:22]};
  assign vt = {rd_q[21:16], rd_q[15:13]};

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_cycles     <= '0;
      object_count    <= '0;
      announced_total <= '0;
      cycle_count     <= '0;
      run_count       <= '0;
      run_done        <= 1'b0;
      walk_idx        <= '0;
      step            <= '0;
    end else begin
      if (cfg_wr_en) skip_cycles <= cfg_wr_data;
      if (cmd.accept && is_object && (object_count < CNT_W'(MAX_OBJECTS))) begin
        object_count <= object_count + CNT_W'(1);
      end
      // A status frame hands the scan to the walk and latches the next totals.
      if (cmd.accept && is_status) begin
        run_count       <= object_count;
        run_done        <= ({1'b0, object_count} == announced_total);
        object_count    <= '0;
        announced_total <= byte0;
        cycle_count     <= {byte1, byte2};
        walk_idx        <= '0;
        step            <= '0;
      end
      if (cmd.div_step) step <= step + STEP_W'(1);
      if (cmd.advance) walk_idx <= walk_idx + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_object && (object_count < CNT_W'(MAX_OBJECTS))) begin
      store[object_count[ADDR_W-1:0]] <= raw_in;
    end
    if (cmd.rd_en) rd_q <= store[walk_idx];
  end

  // Restoring remainder of the previous cycle count, one dividend bit a step.
  always_ff @(posedge clk) begin
    if (cmd.accept && is_status) begin
      dvd <= cycle_count;
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[CYC_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem <= 9'(trial - {1'b0, divisor});
      else rem <= trial[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      detected_count <= run_count;
      complete       <= run_done;
      publish        <= (rem == '0);
      if (stat.empty) begin
        last        <= 1'b1;
        obj_id      <= '0;
        dist_long   <= '0;
        dist_lat    <= '0;
        vel_long    <= '0;
        vel_lat     <= '0;
        obj_class   <= '0;
        dyn_prop    <= '0;
        rcs_half_db <= '0;
      end else begin
        last        <= ({1'b0, walk_idx} + CNT_W'(1) == run_count);
        obj_id      <= {1'b0, rd_q[63:56]} + 9'd1;
        dist_long   <= $signed({1'b0, dl, 1'b0} - DIST_LONG_OFS);
        dist_lat    <= $signed({dt, 1'b0} - DIST_LAT_OFS);
        // Subtracting half the raw range flips only the top bit.
        vel_long    <= $signed({~vl[9], vl[8:0]});
        vel_lat     <= $signed({~vt[8], vt[7:0]});
        obj_class   <= rd_q[12:11];
        dyn_prop    <= rd_q[10:8];
        rcs_half_db <= $signed({~rd_q[7], rd_q[6:0]});
      end
    end
  end

endmodule

FILE: hw/rtl/radar_object_frame_decoder_core.sv
// Radar object frame decoder, top level.
//
// Input channel (in_valid/in_stall) takes one CAN frame per beat: frame_id,
// frame_len and the eight data bytes. Frames with a length other than 8 or
// an unmatched identifier are dropped. An object frame (all bits of 0x60B
// set) is stored; the store holds 64 objects and further ones are dropped
// until the next status frame.
// A status frame (0x60A) starts a run of results on the output channel
// (out_valid/out_stall), one per stored object in arrival order, with last
// on the final beat; an empty scan gives a single beat with obj_id zero.
// Sequence: a status frame first passes through the bit-serial remainder for
// publish, then each result takes a store read, format and show (format and
// show only for an empty scan), plus receiver stalls. The input stalls for
// the whole run of a status frame; object frames are taken without a stall.
// A stalled output beat holds its payload. skip_cycles is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, and the block itself does not enforce it.
// Synchronous reset clears the object count, announced total, cycle count
// and skip_cycles; the store contents are not cleared.
// Depends on rofd_pkg, rofd_ctrl and rofd_datapath.
module radar_object_frame_decoder_core
  import rofd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [10:0]       frame_id,
  input  logic [3:0]        frame_len,
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte1,
  input  logic [7:0]        byte2,
  input  logic [7:0]        byte3,
  input  logic [7:0]        byte4,
  input  logic [7:0]        byte5,
  input  logic [7:0]        byte6,
  input  logic [7:0]        byte7,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              last,
  output logic [8:0]        obj_id,
  output logic signed [14:0] dist_long,
  output logic signed [12:0] dist_lat,
  output logic signed [9:0] vel_long,
  output logic signed [8:0] vel_lat,
  output logic [1:0]        obj_class,
  output logic [2:0]        dyn_prop,
  output logic signed [7:0] rcs_half_db,
  output logic [6:0]        detected_count,
  output logic              complete,
  output logic              publish
);

  rofd_cmd_t  cmd;
  rofd_stat_t stat;

  rofd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rofd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .frame_id       (frame_id),
    .frame_len      (frame_len),
    .byte0          (byte0),
    .byte1          (byte1),
    .byte2          (byte2),
    .byte3          (byte3),
    .byte4          (byte4),
    .byte5          (byte5),
    .byte6          (byte6),
    .byte7          (byte7),
    .cmd            (cmd),
    .stat           (stat),
    .last           (last),
    .obj_id         (obj_id),
    .dist_long      (dist_long),
    .dist_lat       (dist_lat),
    .vel_long       (vel_long),
    .vel_lat        (vel_lat),
    .obj_class      (obj_class),
    .dyn_prop       (dyn_prop),
    .rcs_half_db    (rcs_half_db),
    .detected_count (detected_count),
    .complete       (complete),
    .publish        (publish)
  );

endmodule

FILE: hw/rtl/rofd_checker.sv
// Port-level checks for the radar object frame decoder, bound to the top level.
// Depends on radar_object_frame_decoder_core ports only.
module rofd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       last,
  input logic [8:0] obj_id,
  input logic [6:0] detected_count
);

  // A beat offered on the output holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat withdrawn while stalled");

  // No frame is taken while a result run is on the output.
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during a result run");

  // The run ends with the beat marked last.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && !out_stall |=> !out_valid)
    else $error("output continued past the last beat");

  // Only an empty scan reports no object, and it is a single beat.
  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && (obj_id == 9'd0) |-> last && (detected_count == 7'd0))
    else $error("object-less beat in a non-empty scan");

endmodule

bind radar_object_frame_decoder_core rofd_checker u_rofd_checker (.*);

FILE: tb/rofd_report_check.sv
// Result checker for the radar object frame decoder testbench. It follows the
// object list from the accepted input beats, predicts each result beat and compares it.
// Depends on rofd_pkg.
`timescale 1ns / 100ps
module rofd_report_check
  import rofd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [10:0]       frame_id,
  input  logic [3:0]        frame_len,
  input  logic [7:0]        byte0,
  input  logic [7:0]        byte1,
  input  logic [7:0]        byte2,
  input  logic [7:0]        byte3,
  input  logic [7:0]        byte4,
  input  logic [7:0]        byte5,
  input  logic [7:0]        byte6,
  input  logic [7:0]        byte7,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              last,
  input  logic [8:0]        obj_id,
  input  logic signed [14:0] dist_long,
  input  logic signed [12:0] dist_lat,
  input  logic signed [9:0] vel_long,
  input  logic signed [8:0] vel_lat,
  input  logic [1:0]        obj_class,
  input  logic [2:0]        dyn_prop,
  input  logic signed [7:0] rcs_half_db,
  input  logic [6:0]        detected_count,
  input  logic              complete,
  input  logic              publish,
  output int                errors,
  output int                pending,
  output int                beats_checked
);

  typedef struct packed {
    logic              last;
    logic [8:0]        obj_id;
    logic signed [14:0] dist_long;
    logic signed [12:0] dist_lat;
    logic signed [9:0] vel_long;
    logic signed [8:0] vel_lat;
    logic [1:0]        obj_class;
    logic [2:0]        dyn_prop;
    logic signed [7:0] rcs_half_db;
    logic [6:0]        detected_count;
    logic              complete;
    logic              publish;
  } obj_report_t;

  logic [63:0] scan_buf [MAX_OBJECTS];
  logic [6:0]  scan_cnt;
  logic [7:0]  announced;
  logic [15:0] cycle_no;
  logic [7:0]  skip_cycles;
  obj_report_t report_q [$];
  int          fails = 0;
  int          beats = 0;

  assign errors        = fails;
  assign beats_checked = beats;

  function automatic obj_report_t format_object(input logic [63:0] raw, input logic is_last,
                                                input logic [6:0] count, input logic done,
                                                input logic pub);
    obj_report_t r;
    logic [7:0]  b [8];
    int          i;
    int          dist_raw, lat_raw, vl_raw, vt_raw;
    for (i = 0; i < 8; i++) b[i[2:0]] = raw[63 - 8 * i -: 8];
    dist_raw         = int'({b[1], b[2][7:3]});
    lat_raw          = int'({b[2][2:0], b[3]});
    vl_raw           = int'({b[4], b[5][7:6]});
    vt_raw           = int'({b[5][5:0], b[6][7:5]});
    r.last           = is_last;
    r.obj_id         = 9'(b[0]) + 9'd1;
    r.dist_long      = 15'(dist_raw * 2 - 5000);
    r.dist_lat       = 13'(lat_raw * 2 - 2042);
    r.vel_long       = 10'(vl_raw - 512);
    r.vel_lat        = 9'(vt_raw - 256);
    r.obj_class      = b[6][4:3];
    r.dyn_prop       = b[6][2:0];
    r.rcs_half_db    = 8'(int'(b[7]) - 128);
    r.detected_count = count;
    r.complete       = done;
    r.publish        = pub;
    return r;
  endfunction

  task automatic take_frame(input logic [10:0] id, input logic [3:0] len,
                            input logic [63:0] raw);
    obj_report_t r;
    logic        done, pub;
    int          k;
    if (len != DLC_FULL) return;
    if ((id & ID_OBJECT) == ID_OBJECT) begin
      // Once the store is full, further objects are dropped until the next status frame.
      if (scan_cnt < MAX_OBJECTS) begin
        scan_buf[scan_cnt[5:0]] = raw;
        scan_cnt = scan_cnt + 7'd1;
      end
    end else if ((id & ID_STATUS) == ID_STATUS) begin
      // Both flags use the total and cycle count latched by the previous status frame.
      done = ({1'b0, scan_cnt} == announced);
      pub  = (int'(cycle_no) % (int'(skip_cycles) + 1)) == 0;
      if (scan_cnt == 0) begin
        r          = '0;
        r.last     = 1'b1;
        r.complete = done;
        r.publish  = pub;
        report_q.push_back(r);
      end else begin
        for (k = 0; k < scan_cnt; k++)
          report_q.push_back(format_object(scan_buf[k[5:0]], k == scan_cnt - 1, scan_cnt,
                                           done, pub));
      end
      scan_cnt  = '0;
      announced = raw[63:56];
      cycle_no  = raw[55:40];
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_beat();
    obj_report_t w;
    if (report_q.size() == 0) begin
      $error("result beat with no expected result, obj_id %0d", obj_id);
      fails++;
    end else begin
      w = report_q.pop_front();
      beats++;
      check_field("last", w.last, last);
      check_field("obj_id", w.obj_id, obj_id);
      check_field("dist_long", w.dist_long, dist_long);
      check_field("dist_lat", w.dist_lat, dist_lat);
      check_field("vel_long", w.vel_long, vel_long);
      check_field("vel_lat", w.vel_lat, vel_lat);
      check_field("obj_class", w.obj_class, obj_class);
      check_field("dyn_prop", w.dyn_prop, dyn_prop);
      check_field("rcs_half_db", w.rcs_half_db, rcs_half_db);
      check_field("detected_count", w.detected_count, detected_count);
      check_field("complete", w.complete, complete);
      check_field("publish", w.publish, publish);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_cnt    = '0;
      announced   = '0;
      cycle_no    = '0;
      skip_cycles = '0;
      report_q.delete();
    end else begin
      // Compare before predicting, so a beat never matches a frame taken at the same edge.
      if (out_valid && !out_stall) check_beat();
      if (cfg_wr_en) skip_cycles = cfg_wr_data;
      if (in_valid && !in_stall)
        take_frame(frame_id, frame_len,
                   {byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7});
    end
    pending <= report_q.size();
  end

endmodule

FILE: tb/tb_radar_object_frame_decoder_core.sv
// Testbench top for the radar object frame decoder: clock, reset, frame stimulus,
// receiver stalls and the verdict. Depends on rofd_pkg, rofd_report_check and the core.
`timescale 1ns / 100ps
module tb_radar_object_frame_decoder_core;
  import rofd_pkg::*;

  localparam int LONG_HOLD     = 600;
  localparam int SETTLE        = 30;
  localparam int RANDOM_FRAMES = 64;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              cfg_wr_en   = 1'b0;
  logic [7:0]        cfg_wr_data = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [10:0]       frame_id    = '0;
  logic [3:0]        frame_len   = '0;
  logic [7:0]        byte0 = '0, byte1 = '0, byte2 = '0, byte3 = '0;
  logic [7:0]        byte4 = '0, byte5 = '0, byte6 = '0, byte7 = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic              last;
  logic [8:0]        obj_id;
  logic signed [14:0] dist_long;
  logic signed [12:0] dist_lat;
  logic signed [9:0] vel_long;
  logic signed [8:0] vel_lat;
  logic [1:0]        obj_class;
  logic [2:0]        dyn_prop;
  logic signed [7:0] rcs_half_db;
  logic [6:0]        detected_count;
  logic              complete;
  logic              publish;

  int   errors, pending, beats_checked;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic long_hold      = 1'b0;
  int   hold_count     = 0;
  int   frames_sent    = 0;
  int   scans_sent     = 0;
  logic [7:0] planned_total = '0;

  always #5 clk = ~clk;

  radar_object_frame_decoder_core uut (.*);

  rofd_report_check u_report_check (.*);

  // Receiver: random stalls, or one long hold-off while long_hold is raised.
  always @(posedge clk) begin
    if (long_hold && hold_count < LONG_HOLD) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (!long_hold) hold_count <= 0;
    end
  end

  function automatic logic [10:0] object_id();
    return 11'($urandom) | ID_OBJECT;
  endfunction

  function automatic logic [10:0] status_id();
    return (11'($urandom) | ID_STATUS) & ~(ID_OBJECT ^ ID_STATUS);
  endfunction

  function automatic logic [15:0] pick_cycle();
    case ($urandom_range(0, 3))
      0: return {8'($urandom), 8'h00};
      1: return 16'($urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] status_data(input logic [7:0] total, input logic [15:0] cyc);
    return {total, cyc, 40'({$urandom, $urandom})};
  endfunction

  task automatic send_frame(input logic [10:0] id, input logic [3:0] len,
                            input logic [63:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    frame_id  <= id;
    frame_len <= len;
    {byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7} <= data;
    do @(posedge clk); while (in_stall);
    if (len == DLC_FULL && (id & ID_STATUS) == ID_STATUS) begin
      frames_sent++;
      if ((id & ID_OBJECT) != ID_OBJECT) scans_sent++;
    end
  endtask

  // Stop offering beats until every expected result has come and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_skip(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_noise();
    logic [3:0]  bad_len;
    logic [10:0] id;
    bad_len = 4'($urandom_range(0, 14));
    if (bad_len >= DLC_FULL) bad_len = bad_len + 4'd1;
    id = 11'($urandom);
    case ($urandom_range(0, 2))
      0: send_frame(object_id(), bad_len, {$urandom, $urandom});
      1: send_frame(status_id(), bad_len, {$urandom, $urandom});
      default: begin
        if ((id & ID_STATUS) == ID_STATUS) id[$urandom_range(9, 10)] = 1'b0;
        send_frame(id, DLC_FULL, {$urandom, $urandom});
      end
    endcase
  endtask

  // Well-formed scans: objects, then a status frame that mostly announces the
  // size of the next scan, with some ignored frames mixed in.
  task automatic random_scans(input int stop_at);
    int         n, i;
    logic [7:0] next_total;
    while (frames_sent < stop_at) begin
      n = ($urandom_range(0, 3) != 0) ? int'(planned_total) : int'($urandom_range(0, 8));
      if (n > 10) n = $urandom_range(0, 10);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        send_frame(object_id(), DLC_FULL, {$urandom, $urandom});
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      next_total = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      send_frame(status_id(), DLC_FULL, status_data(next_total, pick_cycle()));
      planned_total = next_total;
    end
  endtask

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_skip(8'd0);

    // Directed frames: field extremes, ignored frames and empty scans.
    send_frame(ID_STATUS, DLC_FULL, status_data(8'd2, 16'hFFFF));
    send_frame(ID_OBJECT, DLC_FULL, 64'h0);
    send_frame(11'h7FF, DLC_FULL, {64{1'b1}});
    send_frame(ID_OBJECT, 4'd7, {$urandom, $urandom});
    send_frame(ID_STATUS, 4'd15, {$urandom, $urandom});
    send_frame(11'h000, DLC_FULL, {$urandom, $urandom});
    send_frame(11'h5FF, DLC_FULL, {$urandom, $urandom});
    send_frame(11'h7FE, DLC_FULL, status_data(8'd1, 16'h0100));
    send_frame(11'h6AB, DLC_FULL, 64'h7F80_0004_0020_1C80);
    send_frame(ID_STATUS, DLC_FULL, status_data(8'd0, 16'h0003));
    send_frame(ID_STATUS, DLC_FULL, status_data(8'd4, 16'h0000));
    send_frame(11'h60E, DLC_FULL, status_data(8'd0, 16'h0100));
    drain();

    set_skip(8'd255);
    send_frame(ID_STATUS, DLC_FULL, status_data(8'd0, 16'h00FF));
    send_frame(ID_STATUS, DLC_FULL, status_data(8'd1, 16'h8000));
    send_frame(object_id(), DLC_FULL, {$urandom, $urandom});
    send_frame(ID_STATUS, DLC_FULL, status_data(8'd0, 16'h0001));
    send_frame(ID_STATUS, DLC_FULL, status_data(8'd0, 16'h0000));
    drain();

    // Overfill the store, then hold the receiver off so the run backs up into the input.
    set_skip(8'd1);
    send_frame(status_id(), DLC_FULL, status_data(8'd64, 16'd2));
    for (i = 0; i < MAX_OBJECTS + 2; i++)
      send_frame(object_id(), DLC_FULL, {$urandom, $urandom});
    long_hold <= 1'b1;
    send_frame(status_id(), DLC_FULL, status_data(8'd1, 16'd5));
    send_frame(object_id(), DLC_FULL, {$urandom, $urandom});
    send_frame(status_id(), DLC_FULL, status_data(8'd0, 16'hFFFE));
    drain();
    long_hold <= 1'b0;

    set_skip(8'd3);
    random_scans(frames_sent + RANDOM_FRAMES / 4);
    drain();

    send_idle_pct = 73;
    random_scans(frames_sent + RANDOM_FRAMES / 4);
    drain();
    set_skip(8'($urandom_range(2, 254)));

    send_idle_pct = 0;
    recv_stall_pct <= 73;
    random_scans(frames_sent + RANDOM_FRAMES / 4);
    drain();
    set_skip(8'd0);

    send_idle_pct = 37;
    recv_stall_pct <= 37;
    random_scans(frames_sent + RANDOM_FRAMES / 4);
    drain();

    $display("Run covered %0d decoded frames in %0d scans and %0d checked result beats,",
             frames_sent, scans_sent, beats_checked);
    $display("with empty scans, an overfilled store and skip_cycles from 0 up to 255.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
